### hdl/wroc_pkg.sv
package wroc_pkg;

  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 64;

  localparam logic [4:0] AddrRadius  = 5'd0;
  localparam logic [4:0] AddrSpacing = 5'd4;
  localparam logic [4:0] AddrAxis    = 5'd8;
  localparam logic [4:0] AddrSide    = 5'd12;
  localparam logic [4:0] AddrTilt    = 5'd16;

  typedef struct packed {
    logic [63:0] rad;
    logic [35:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [63:0] num;
    logic [36:0] rem;
    logic [63:0] quo;
    logic [36:0] den;
  } dv_t;

endpackage

### hdl/wroc_sqrt_cell.sv
module wroc_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  wroc_pkg::sq_t  d,
  output wroc_pkg::sq_t  q
);

  wroc_pkg::sq_t nxt;
  logic [35:0] r2;
  logic [35:0] trial;

  always_comb begin
    r2 = {d.rem[33:0], d.rad[63:62]};
    trial = {2'b00, d.root, 2'b01};
    nxt.rad = {d.rad[61:0], 2'b00};
    if (r2 >= trial) begin
      nxt.rem = r2 - trial;
      nxt.root = {d.root[30:0], 1'b1};
    end else begin
      nxt.rem = r2;
      nxt.root = {d.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end

endmodule

### hdl/wroc_div_cell.sv
module wroc_div_cell (
  input  logic           clk,
  input  logic           en,
  input  wroc_pkg::dv_t  d,
  output wroc_pkg::dv_t  q
);

  wroc_pkg::dv_t nxt;
  logic [37:0] r2;
  logic [37:0] diff;

  always_comb begin
    r2 = {d.rem, d.num[63]};
    diff = r2 - {1'b0, d.den};
    nxt.num = {d.num[62:0], 1'b0};
    nxt.den = d.den;
    if (r2 >= {1'b0, d.den}) begin
      nxt.rem = diff[36:0];
      nxt.quo = {d.quo[62:0], 1'b1};
    end else begin
      nxt.rem = r2[36:0];
      nxt.quo = {d.quo[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= nxt;
  end

endmodule

### hdl/wire_roller_offset_compensation_unit.sv
// Wire roller offset compensation unit.
// Input channel: offset_u, offset_v with in_valid / in_stall; an item is
// taken at a clock edge with in_valid high and in_stall low.
// Output channel: error_x, error_y with out_valid / out_stall; one result
// item per input item, in order.
// Configuration: APB-style write port, registers at byte addresses 0, 4, 8,
// 12 and 16; write only while no item is in flight.
// The path from acceptance to out_valid is a chain of cells: 32 square-root
// cells (one root bit each), 64 divider cells for y and the ratio, then 64
// divider cells for x, one quotient bit per cell.
// Throughput: one item per cycle while not frozen; every cell then hands its value on.
// When out_stall holds a waiting result, the whole chain freezes and
// in_stall rises in the same cycle; nothing is lost.
// Reset: configuration registers clear to zero and the chain empties its valid bits.
module wire_roller_offset_compensation_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [20:0] offset_u,
  input  logic signed [20:0] offset_v,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] error_x,
  output logic signed [31:0] error_y
);

  typedef struct packed {
    logic [20:0] ma;
    logic [20:0] mb;
    logic        na;
    logic        nb;
  } side_a_t;

  typedef struct packed {
    logic [46:0] ka;
    logic        na;
    logic        nb;
  } side_b_t;

  typedef struct packed {
    logic [63:0] yq;
    logic        na;
    logic        nb;
  } side_c_t;

  logic [16:0] radius;
  logic [20:0] spacing;
  logic        axis;
  logic        side;
  logic        tilt;

  logic en;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= '0;
      spacing <= '0;
      axis <= 1'b0;
      side <= 1'b0;
      tilt <= 1'b0;
    end else if (wr) begin
      unique case (paddr)
        wroc_pkg::AddrRadius:  radius <= pwdata[16:0];
        wroc_pkg::AddrSpacing: spacing <= pwdata[20:0];
        wroc_pkg::AddrAxis:    axis <= pwdata[0];
        wroc_pkg::AddrSide:    side <= pwdata[0];
        wroc_pkg::AddrTilt:    tilt <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      wroc_pkg::AddrRadius:  prdata = {15'd0, radius};
      wroc_pkg::AddrSpacing: prdata = {11'd0, spacing};
      wroc_pkg::AddrAxis:    prdata = {31'd0, axis};
      wroc_pkg::AddrSide:    prdata = {31'd0, side};
      wroc_pkg::AddrTilt:    prdata = {31'd0, tilt};
      default:               prdata = '0;
    endcase
  end

  logic [26:0] kr;
  assign kr = 27'(radius * 10'd1000);

  // input stage: magnitudes and axis swap
  logic [20:0] mu, mv;
  logic        nu, nv;
  assign nu = offset_u[20];
  assign nv = offset_v[20];
  assign mu = nu ? 21'(21'h0 - offset_u) : offset_u;
  assign mv = nv ? 21'(21'h0 - offset_v) : offset_v;

  logic    v0;
  side_a_t s0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0.ma <= axis ? mv : mu;
      s0.na <= axis ? nv : nu;
      s0.mb <= axis ? mu : mv;
      s0.nb <= axis ? nu : nv;
    end
  end

  // squares
  logic        v1;
  side_a_t     s1;
  logic [41:0] ll;
  logic [41:0] aa, bb;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s0;
      ll <= 42'(spacing * spacing);
      aa <= 42'(s0.ma * s0.ma);
      bb <= 42'(s0.mb * s0.mb);
    end
  end

  // square root chains
  logic [42:0] suma, sumb;
  assign suma = {1'b0, ll} + {1'b0, aa};
  assign sumb = {1'b0, ll} + {1'b0, bb};

  wroc_pkg::sq_t sqa [wroc_pkg::SqrtSteps+1];
  wroc_pkg::sq_t sqb [wroc_pkg::SqrtSteps+1];

  assign sqa[0] = '{rad: {1'b0, suma, 20'd0}, rem: '0, root: '0};
  assign sqb[0] = '{rad: {1'b0, sumb, 20'd0}, rem: '0, root: '0};

  for (genvar i = 0; i < wroc_pkg::SqrtSteps; i++) begin : g_sq
    wroc_sqrt_cell u_a (.clk(clk), .en(en), .d(sqa[i]), .q(sqa[i+1]));
    wroc_sqrt_cell u_b (.clk(clk), .en(en), .d(sqb[i]), .q(sqb[i+1]));
  end

  side_a_t                      la [wroc_pkg::SqrtSteps];
  logic [wroc_pkg::SqrtSteps-1:0] lva;

  always_ff @(posedge clk) begin
    if (rst) lva <= '0;
    else if (en) lva <= {lva[wroc_pkg::SqrtSteps-2:0], v1};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      la[0] <= s1;
      for (int i = 1; i < wroc_pkg::SqrtSteps; i++) la[i] <= la[i-1];
    end
  end

  // numerators for y and ratio
  logic [31:0] sa, sb, diff;
  side_a_t     ea;
  assign sa = sqa[wroc_pkg::SqrtSteps].root;
  assign sb = sqb[wroc_pkg::SqrtSteps].root;
  assign ea = la[wroc_pkg::SqrtSteps-1];
  assign diff = sb - {1'b0, spacing, 10'd0};

  logic        v3;
  logic [63:0] ynum;
  logic [36:0] yden;
  logic [63:0] rnum;
  logic [36:0] rden;
  side_b_t     s3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= lva[wroc_pkg::SqrtSteps-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ynum <= 64'(kr * diff);
      yden <= tilt ? {5'd0, sa} : {6'd0, spacing, 10'd0};
      rnum <= {17'd0, ea.mb, 26'd0};
      rden <= {5'd0, sb};
      s3.ka <= 47'(kr * ea.ma);
      s3.na <= ea.na;
      s3.nb <= ea.nb;
    end
  end

  wroc_pkg::dv_t dy [wroc_pkg::DivSteps+1];
  wroc_pkg::dv_t dr [wroc_pkg::DivSteps+1];

  assign dy[0] = '{num: ynum + {28'd0, yden[36:1]}, rem: '0, quo: '0, den: yden};
  assign dr[0] = '{num: rnum, rem: '0, quo: '0, den: rden};

  for (genvar i = 0; i < wroc_pkg::DivSteps; i++) begin : g_d1
    wroc_div_cell u_y (.clk(clk), .en(en), .d(dy[i]), .q(dy[i+1]));
    wroc_div_cell u_r (.clk(clk), .en(en), .d(dr[i]), .q(dr[i+1]));
  end

  side_b_t                       lb [wroc_pkg::DivSteps];
  logic [wroc_pkg::DivSteps-1:0] lvb;

  always_ff @(posedge clk) begin
    if (rst) lvb <= '0;
    else if (en) lvb <= {lvb[wroc_pkg::DivSteps-2:0], v3};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lb[0] <= s3;
      for (int i = 1; i < wroc_pkg::DivSteps; i++) lb[i] <= lb[i-1];
    end
  end

  // x numerator
  side_b_t     eb;
  logic [16:0] rq;
  assign eb = lb[wroc_pkg::DivSteps-1];
  assign rq = dr[wroc_pkg::DivSteps].quo[16:0];

  logic        v4;
  logic [63:0] xnum;
  side_c_t     s4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= lvb[wroc_pkg::DivSteps-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xnum <= 64'(eb.ka * rq);
      s4.yq <= dy[wroc_pkg::DivSteps].quo;
      s4.na <= eb.na;
      s4.nb <= eb.nb;
    end
  end

  wroc_pkg::dv_t dx [wroc_pkg::DivSteps+1];
  assign dx[0] = '{num: xnum + {28'd0, spacing, 15'd0}, rem: '0, quo: '0,
                   den: {spacing, 16'd0}};

  for (genvar i = 0; i < wroc_pkg::DivSteps; i++) begin : g_d2
    wroc_div_cell u_x (.clk(clk), .en(en), .d(dx[i]), .q(dx[i+1]));
  end

  side_c_t                       lc [wroc_pkg::DivSteps];
  logic [wroc_pkg::DivSteps-1:0] lvc;

  always_ff @(posedge clk) begin
    if (rst) lvc <= '0;
    else if (en) lvc <= {lvc[wroc_pkg::DivSteps-2:0], v4};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lc[0] <= s4;
      for (int i = 1; i < wroc_pkg::DivSteps; i++) lc[i] <= lc[i-1];
    end
  end

  // sign, saturate, swap
  side_c_t     ec;
  logic [63:0] xmag, ymag;
  logic        xneg, yneg;
  logic [31:0] xo, yo;
  assign ec = lc[wroc_pkg::DivSteps-1];
  assign xmag = tilt ? 64'd0 : dx[wroc_pkg::DivSteps].quo;
  assign ymag = ec.yq;
  assign yneg = !side;
  assign xneg = side ? (ec.na != ec.nb) : (ec.na == ec.nb);

  always_comb begin
    if (xneg) xo = (xmag > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - xmag);
    else      xo = (xmag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : xmag[31:0];
    if (yneg) yo = (ymag > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - ymag);
    else      yo = (ymag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : ymag[31:0];
    if (spacing == 21'd0) begin
      xo = '0;
      yo = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= lvc[wroc_pkg::DivSteps-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      error_x <= axis ? yo : xo;
      error_y <= axis ? xo : yo;
    end
  end

endmodule

### bench/wire_roller_offset_compensation_unit_tb.sv
`timescale 1ns / 1ps

module wire_roller_offset_compensation_unit_tb;

  localparam int WatchdogLimit = 20000;
  localparam int Latency = 165;

  typedef struct packed {
    logic signed [31:0] ex;
    logic signed [31:0] ey;
  } wire_error_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid;
  logic in_stall;
  logic signed [20:0] offset_u, offset_v;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] error_x, error_y;

  logic [16:0] radius_q;
  logic [20:0] spacing_q;
  logic axis_q, side_q, tilt_q;

  wire_error_t pending_errors[$];
  int mismatch_count;
  int result_count;
  int item_count;
  int idle_cycles;
  int send_gap_pct;
  int stall_pct;

  wire_roller_offset_compensation_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .offset_u(offset_u), .offset_v(offset_v),
    .out_valid(out_valid), .out_stall(out_stall),
    .error_x(error_x), .error_y(error_y)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] root_bits(input logic [63:0] n);
    logic [63:0] res, bitv, rem;
    res = 0;
    rem = n;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] clamp32(input logic [63:0] mag, input logic neg);
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return 32'(-mag);
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  function automatic wire_error_t predict_error(input logic signed [20:0] u,
                                                input logic signed [20:0] v);
    wire_error_t res;
    logic [63:0] mu, mv, ma, mb, l, kr, sa, sb, ratio, ymag, xmag;
    logic nu, nv, na, nb, xneg, yneg;
    logic [31:0] xo, yo;
    nu = u[20];
    nv = v[20];
    mu = nu ? 64'(-(64'(u))) & 64'h1F_FFFF : 64'(u[19:0]);
    mv = nv ? 64'(-(64'(v))) & 64'h1F_FFFF : 64'(v[19:0]);
    if (nu) mu = 64'h20_0000 - 64'(u[20:0]);
    if (nv) mv = 64'h20_0000 - 64'(v[20:0]);
    if (!axis_q) begin
      ma = mu; na = nu; mb = mv; nb = nv;
    end else begin
      ma = mv; na = nv; mb = mu; nb = nu;
    end
    res = '0;
    l = 64'(spacing_q);
    if (l == 0) return res;
    kr = 64'd1000 * 64'(radius_q);
    sb = root_bits((l * l + mb * mb) << 20);
    xmag = 0;
    xneg = 1'b0;
    yneg = !side_q;
    if (tilt_q) begin
      sa = root_bits((l * l + ma * ma) << 20);
      ymag = (kr * (sb - (l << 10)) + sa / 2) / sa;
    end else begin
      ratio = (mb << 26) / sb;
      ymag = (kr * (sb - (l << 10)) + (l << 9)) / (l << 10);
      xmag = (kr * ma * ratio + (l << 15)) / (l << 16);
      xneg = side_q ? (na != nb) : (na == nb);
    end
    xo = clamp32(xmag, xneg && xmag != 0);
    yo = clamp32(ymag, yneg && ymag != 0);
    if (!axis_q) begin
      res.ex = xo; res.ey = yo;
    end else begin
      res.ex = yo; res.ey = xo;
    end
    return res;
  endfunction

  task automatic write_reg(input logic [4:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      wroc_pkg::AddrRadius: radius_q = value[16:0];
      wroc_pkg::AddrSpacing: spacing_q = value[20:0];
      wroc_pkg::AddrAxis: axis_q = value[0];
      wroc_pkg::AddrSide: side_q = value[0];
      wroc_pkg::AddrTilt: tilt_q = value[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_geometry(input logic [16:0] r, input logic [20:0] l,
                              input logic ax, input logic sd, input logic tl);
    in_valid <= 1'b0;
    wait (pending_errors.size() == 0);
    @(negedge clk);
    write_reg(wroc_pkg::AddrRadius, 32'(r));
    write_reg(wroc_pkg::AddrSpacing, 32'(l));
    write_reg(wroc_pkg::AddrAxis, 32'(ax));
    write_reg(wroc_pkg::AddrSide, 32'(sd));
    write_reg(wroc_pkg::AddrTilt, 32'(tl));
  endtask

  task automatic send_offsets(input logic signed [20:0] u, input logic signed [20:0] v);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    offset_u <= u;
    offset_v <= v;
    do @(posedge clk); while (in_stall);
    pending_errors.push_back(predict_error(u, v));
    item_count++;
    @(negedge clk);
  endtask

  function automatic logic signed [20:0] rand_offset();
    case ($urandom_range(5))
      0: return 21'(-1000000 + $urandom_range(2000000));
      1: return 21'($urandom);
      2: return 21'($signed($urandom_range(2000)) - 1000);
      3: return $urandom_range(1) ? 21'sd1000000 : -21'sd1000000;
      default: return 21'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_offsets(21'sd5000, -21'sd3000);
    send_offsets(21'sd0, 21'sd0);
  endtask

  task automatic test_directed();
    logic signed [20:0] edges[6];
    edges = '{21'sd0, 21'sd1, -21'sd1, 21'sd1000000, -21'sd1000000, -21'sd1048576};
    set_geometry(17'd100000, 21'd1, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 6; i++) send_offsets(edges[i], edges[5 - i]);
    set_geometry(17'd131071, 21'd2097151, 1'b1, 1'b1, 1'b0);
    send_offsets(21'sd1048575, -21'sd1048576);
    send_offsets(-21'sd1048576, 21'sd1048575);
    set_geometry(17'd100000, 21'd2000000, 1'b0, 1'b1, 1'b1);
    for (int i = 0; i < 4; i++) send_offsets(edges[i + 2], edges[i]);
    set_geometry(17'd0, 21'd50000, 1'b1, 1'b0, 1'b1);
    send_offsets(21'sd300000, -21'sd200000);
    set_geometry(17'd50000, 21'd0, 1'b0, 1'b0, 1'b1);
    send_offsets(21'sd300000, -21'sd200000);
    set_geometry(17'd20000, 21'd10, 1'b1, 1'b1, 1'b1);
    send_offsets(-21'sd1000000, 21'sd7);
    send_offsets(21'sd7, -21'sd1000000);
  endtask

  task automatic test_random_phase(input int items);
    for (int blk = 0; blk < items / 50; blk++) begin
      set_geometry(($urandom_range(3) == 0) ? 17'($urandom) : 17'($urandom_range(100000)),
                   ($urandom_range(5) == 0) ? 21'($urandom_range(20)) :
                   21'($urandom_range(2000000)),
                   1'($urandom), 1'($urandom), 1'($urandom));
      for (int i = 0; i < 50; i++) send_offsets(rand_offset(), rand_offset());
    end
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    wire_error_t want;
    if (!rst && out_valid && !out_stall) begin
      result_count++;
      if (pending_errors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result x=%0d y=%0d", error_x, error_y);
      end else begin
        want = pending_errors.pop_front();
        if (error_x !== want.ex || error_y !== want.ey) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                     want.ex, want.ey, error_x, error_y);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; offset_u = '0; offset_v = '0;
    radius_q = '0; spacing_q = '0; axis_q = 1'b0; side_q = 1'b0; tilt_q = 1'b0;
    mismatch_count = 0; result_count = 0; item_count = 0; idle_cycles = 0;
    send_gap_pct = 10; stall_pct = 68;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_directed();
    test_random_phase(200);
    send_gap_pct = 68; stall_pct = 10;
    test_random_phase(200);
    send_gap_pct = 0; stall_pct = 0;
    test_random_phase(200);
    in_valid <= 1'b0;
    wait (pending_errors.size() == 0);
    repeat (Latency + 20) @(posedge clk);
    $display("Covered %0d items, %0d results, flat and tilted modes on both axes and sides.",
             item_count, result_count);
    if (mismatch_count == 0 && pending_errors.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
